[rtl/cfpc_pkg.sv]
// Shared types, constants and the CRC-32 byte update for the frame checker.
package cfpc_pkg;

	localparam int unsigned HEADER_BYTES = 36;
	localparam int unsigned CNT_W        = 33;
	localparam logic [CNT_W-1:0] COUNT_MAX = 33'h1_FFFF_FFFF;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [3:0][7:0] MAGIC = {8'h44, 8'h41, 8'h34, 8'h56};

	localparam logic [15:0] RST_VERSION   = 16'd1;
	localparam logic [31:0] RST_FLAG_MASK = 32'd0;
	localparam logic [31:0] RST_MAX_LEN   = 32'd1048576;

	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_VERSION   = 2'd0;
	localparam logic [1:0] REG_FLAG_MASK = 2'd1;
	localparam logic [1:0] REG_MAX_LEN   = 2'd2;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_TOO_SMALL = 4'd1;
	localparam logic [3:0] ST_MAGIC     = 4'd2;
	localparam logic [3:0] ST_VERSION   = 4'd3;
	localparam logic [3:0] ST_FLAGS     = 4'd4;
	localparam logic [3:0] ST_TOO_LARGE = 4'd5;
	localparam logic [3:0] ST_SHORT     = 4'd6;
	localparam logic [3:0] ST_TRAILING  = 4'd7;
	localparam logic [3:0] ST_CRC       = 4'd8;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_last;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [3:0]  status;
		logic [15:0] version;
		logic [15:0] msg_type;
		logic [31:0] frame_flags;
		logic [63:0] request_ident;
		logic [63:0] sequence_number;
		logic [31:0] pay_len;
		logic        run_last;
	} out_word_t;

	typedef struct packed {
		logic [15:0] expected_version;
		logic [31:0] allowed_flags_mask;
		logic [31:0] max_payload_bytes;
	} cfg_t;

	typedef struct packed {
		logic [1:0] cnt;
		out_word_t  word0;
		out_word_t  word1;
	} push_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[rtl/cfpc_regs.sv]
// APB register file holding the checker configuration.
module cfpc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cfpc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output cfpc_pkg::cfg_t               cfg
);

	cfpc_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version   <= cfpc_pkg::RST_VERSION;
			cfg_q.allowed_flags_mask <= cfpc_pkg::RST_FLAG_MASK;
			cfg_q.max_payload_bytes  <= cfpc_pkg::RST_MAX_LEN;
		end else if (wr_en) begin
			case (paddr[3:2])
				cfpc_pkg::REG_VERSION:   cfg_q.expected_version   <= pwdata[15:0];
				cfpc_pkg::REG_FLAG_MASK: cfg_q.allowed_flags_mask <= pwdata;
				cfpc_pkg::REG_MAX_LEN:   cfg_q.max_payload_bytes  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			cfpc_pkg::REG_VERSION:   prdata = {16'd0, cfg_q.expected_version};
			cfpc_pkg::REG_FLAG_MASK: prdata = cfg_q.allowed_flags_mask;
			cfpc_pkg::REG_MAX_LEN:   prdata = cfg_q.max_payload_bytes;
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

[rtl/cfpc_core.sv]
// Input register, frame state, header capture, CRC and status decision.
module cfpc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cfpc_pkg::in_word_t  in_data,
	input  cfpc_pkg::cfg_t      cfg,
	input  logic                room,
	output cfpc_pkg::push_t     push
);

	localparam int unsigned HB = cfpc_pkg::HEADER_BYTES;
	localparam int unsigned CW = cfpc_pkg::CNT_W;

	cfpc_pkg::in_word_t in_s1;
	logic               vld_s1;
	logic               go;

	logic [CW-1:0] cnt_q;
	logic          magic_q;
	logic [7:0]    hdr_q [HB];
	logic [31:0]   crc_q;

	logic [CW-1:0] cnt_n;
	logic          magic_n;
	logic [7:0]    hdr_n [HB];
	logic [31:0]   crc_n;
	logic          is_hdr;
	logic [7:0]    b;
	logic          last;

	logic [15:0] ver, typ;
	logic [31:0] flg, len, crc_fld;
	logic [63:0] rid, seq;
	logic [CW-1:0] expect_cnt;
	logic [3:0]  st;

	cfpc_pkg::out_word_t pay_w, st_w;

	assign go       = vld_s1 && room;
	assign in_stall = vld_s1 && !room;
	assign b        = in_s1.data_byte;
	assign last     = in_s1.frame_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			vld_s1 <= 1'b1;
		end else if (go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_data;
		end
	end

	always_comb begin
		is_hdr  = cnt_q < CW'(HB);
		cnt_n   = (cnt_q == cfpc_pkg::COUNT_MAX) ? cnt_q : cnt_q + CW'(1);
		magic_n = magic_q;
		if (cnt_q < CW'(4) && b != cfpc_pkg::MAGIC[cnt_q[1:0]]) begin
			magic_n = 1'b0;
		end
		for (int i = 0; i < HB; i++) begin
			hdr_n[i] = (is_hdr && cnt_q[5:0] == 6'(i)) ? b : hdr_q[i];
		end
		crc_n = is_hdr ? crc_q : cfpc_pkg::crc_byte(crc_q, b);
	end

	always_comb begin
		ver        = {hdr_n[5], hdr_n[4]};
		typ        = {hdr_n[7], hdr_n[6]};
		flg        = {hdr_n[11], hdr_n[10], hdr_n[9], hdr_n[8]};
		rid        = {hdr_n[19], hdr_n[18], hdr_n[17], hdr_n[16],
		              hdr_n[15], hdr_n[14], hdr_n[13], hdr_n[12]};
		seq        = {hdr_n[27], hdr_n[26], hdr_n[25], hdr_n[24],
		              hdr_n[23], hdr_n[22], hdr_n[21], hdr_n[20]};
		len        = {hdr_n[31], hdr_n[30], hdr_n[29], hdr_n[28]};
		crc_fld    = {hdr_n[35], hdr_n[34], hdr_n[33], hdr_n[32]};
		expect_cnt = CW'(HB) + {1'b0, len};

		if (cnt_n < CW'(HB)) begin
			st = cfpc_pkg::ST_TOO_SMALL;
		end else if (!magic_n) begin
			st = cfpc_pkg::ST_MAGIC;
		end else if (ver != cfg.expected_version) begin
			st = cfpc_pkg::ST_VERSION;
		end else if ((flg & ~cfg.allowed_flags_mask) != 32'd0) begin
			st = cfpc_pkg::ST_FLAGS;
		end else if (len > cfg.max_payload_bytes) begin
			st = cfpc_pkg::ST_TOO_LARGE;
		end else if (cnt_n < expect_cnt) begin
			st = cfpc_pkg::ST_SHORT;
		end else if (cnt_n > expect_cnt) begin
			st = cfpc_pkg::ST_TRAILING;
		end else if (~crc_n != crc_fld) begin
			st = cfpc_pkg::ST_CRC;
		end else begin
			st = cfpc_pkg::ST_OK;
		end
	end

	always_comb begin
		pay_w              = '0;
		pay_w.kind         = cfpc_pkg::KIND_PAYLOAD;
		pay_w.payload_byte = b;
		pay_w.run_last     = !last;

		st_w                 = '0;
		st_w.kind            = cfpc_pkg::KIND_STATUS;
		st_w.status          = st;
		st_w.version         = ver;
		st_w.msg_type        = typ;
		st_w.frame_flags     = flg;
		st_w.request_ident   = rid;
		st_w.sequence_number = seq;
		st_w.pay_len         = len;
		st_w.run_last        = 1'b1;

		push       = '0;
		push.word0 = is_hdr ? st_w : pay_w;
		push.word1 = st_w;
		if (go) begin
			push.cnt = 2'({1'b0, !is_hdr} + {1'b0, last});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			magic_q <= 1'b1;
			crc_q   <= cfpc_pkg::CRC_INIT;
			for (int i = 0; i < HB; i++) begin
				hdr_q[i] <= 8'd0;
			end
		end else if (go) begin
			if (last) begin
				cnt_q   <= '0;
				magic_q <= 1'b1;
				crc_q   <= cfpc_pkg::CRC_INIT;
				for (int i = 0; i < HB; i++) begin
					hdr_q[i] <= 8'd0;
				end
			end else begin
				cnt_q   <= cnt_n;
				magic_q <= magic_n;
				crc_q   <= crc_n;
				for (int i = 0; i < HB; i++) begin
					hdr_q[i] <= hdr_n[i];
				end
			end
		end
	end

endmodule

[rtl/cfpc_fifo.sv]
// Four-entry result queue taking up to two words per cycle.
module cfpc_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfpc_pkg::push_t      push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cfpc_pkg::out_word_t  out_data
);

	cfpc_pkg::out_word_t mem [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] count_q;
	logic       pop;

	assign out_valid = count_q != 3'd0;
	assign pop       = out_valid && !out_stall;
	assign room      = count_q <= 3'd2;
	assign out_data  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.word0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_q + 2'd1] <= push.word1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 3'd0;
		end else begin
			wr_q    <= wr_q + push.cnt;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push.cnt} - {2'b00, pop};
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue over capacity");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> (count_q <= 3'd2))
		else $error("push without room for two words");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q + {1'b0, push.cnt} - {2'b00, pop})))
		else $error("queue count out of step with push and pop");
`endif

endmodule

[rtl/crc_framed_packet_checker.sv]
// Top level of the length-prefixed frame checker with CRC-32 payload check.
// Usage:
//   Input channel (in_valid, in_stall, in_data) takes one frame byte per word,
//   with frame_last set on the final byte. The first 36 bytes are the header.
//   Output channel (out_valid, out_stall, out_data) gives one word per header-
//   less byte (kind 0, payload pass-through) and one status word (kind 1) with
//   the decoded header fields after the final byte of each frame.
//   The APB port sets expected version, allowed flag mask and payload limit.
// Timing:
//   A byte taken is held in the input register and processed there once the
//   queue has room; its words are then written into the result queue.
//   One byte per cycle is sustained while the queue has room; a final payload
//   byte yields two words, drained from a four-word result queue.
// Reset:
//   Registers return to defaults, frame state clears and the queue empties.
// Stall:
//   Queued words hold on out_stall; when more than two wait, a byte in the
//   input register holds there and in_stall rises until space frees up.
module crc_framed_packet_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cfpc_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  cfpc_pkg::in_word_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output cfpc_pkg::out_word_t           out_data
);

	cfpc_pkg::cfg_t  cfg;
	cfpc_pkg::push_t push;
	logic            room;

	cfpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cfpc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg),
		.room     (room),
		.push     (push)
	);

	cfpc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
